// ===== src/segment_tree_point_add_range_sum_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment tree block
// Each macro expands to a concurrent assertion on clk, or to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TREE_POINT_ADD_RANGE_SUM_ASSERT_SVH
`define SEGMENT_TREE_POINT_ADD_RANGE_SUM_ASSERT_SVH
`ifndef SYNTHESIS
// Check outside reset; uses the clk and rst_n of the enclosing module.
`define ST_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);
// Check on every edge, reset included.
`define ST_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) expr) else $error(msg);
`else
`define ST_ASSERT(lbl, expr, msg)
`define ST_ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

// ===== src/segtree_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtree_pkg
// Field widths, operation codes and shared types of the segment tree block.
// ----------------------------------------------------------------------------
package segtree_pkg;

  localparam int OP_W    = 2;
  localparam int POS_W   = 10;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 64;
  localparam int SIZE_W  = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Node store access strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== src/segtree_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtree_mem
// Node sum store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module segtree_mem #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                                      clk,
  input  segtree_pkg::mem_ctl_t                     mem_ctl,
  input  logic [$clog2(2*MAX_LEAVES)-1:0]           waddr,
  input  logic [$clog2(2*MAX_LEAVES)-1:0]           raddr,
  input  logic [segtree_pkg::SUM_W-1:0]             wdata,
  output logic [segtree_pkg::SUM_W-1:0]             rdata
);
  import segtree_pkg::*;

  localparam int NODES = 2 * MAX_LEAVES;

  logic [SUM_W-1:0] mem_r [NODES];
  logic [SUM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/segtree_ctrl.sv =====
`timescale 1ns / 1ps
`include "segment_tree_point_add_range_sum_assert.svh"
// ----------------------------------------------------------------------------
// segtree_ctrl
// Sequencer for add, query and clear, around one shared 64-bit adder.
// ----------------------------------------------------------------------------
module segtree_ctrl #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [segtree_pkg::OP_W-1:0]          in_op,
  input  logic [segtree_pkg::POS_W-1:0]         in_position,
  input  logic signed [segtree_pkg::DELTA_W-1:0] in_delta,
  input  logic [segtree_pkg::POS_W-1:0]         in_range_low,
  input  logic [segtree_pkg::POS_W-1:0]         in_range_high,
  input  logic [segtree_pkg::SIZE_W-1:0]        active_size,
  input  logic                                  res_hold,
  output logic                                  res_done,
  output logic [segtree_pkg::SUM_W-1:0]         res_sum,
  output segtree_pkg::mem_ctl_t                 mem_ctl,
  output logic [$clog2(2*MAX_LEAVES)-1:0]       mem_waddr,
  output logic [$clog2(2*MAX_LEAVES)-1:0]       mem_raddr,
  output logic [segtree_pkg::SUM_W-1:0]         mem_wdata,
  input  logic [segtree_pkg::SUM_W-1:0]         mem_rdata
);
  import segtree_pkg::*;

  localparam int AW    = $clog2(2 * MAX_LEAVES);
  localparam int PW    = AW + 1;
  localparam int CW    = (PW > SIZE_W) ? PW : SIZE_W;
  localparam int NODES = 2 * MAX_LEAVES;

  localparam logic [CW-1:0] ML_C      = CW'(MAX_LEAVES);
  localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
  localparam logic [AW-1:0] ROOT_NODE = AW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_ARD  = 3'd2;
  localparam logic [2:0] S_AWR  = 3'd3;
  localparam logic [2:0] S_QA   = 3'd4;
  localparam logic [2:0] S_QB   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      node_r, node_nxt;
  logic [AW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [PW-1:0]      a_r, a_nxt;
  logic [PW-1:0]      b_r, b_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic               rd_pend_r, rd_pend_nxt;

  logic [CW-1:0]      size_c, pos_c, lo_c, hi_c, hi_clip;
  logic               add_ok, q_ok;
  logic [AW-1:0]      leaf_node;
  logic [PW-1:0]      a_init, b_init, b_dec;
  logic [SUM_W-1:0]   opb, sum, acc_upd;

  // Effective size and span clipping
  assign size_c    = (CW'(active_size) > ML_C) ? ML_C : CW'(active_size);
  assign pos_c     = CW'(in_position);
  assign lo_c      = CW'(in_range_low);
  assign hi_c      = CW'(in_range_high);
  assign add_ok    = pos_c < size_c;
  assign q_ok      = (size_c != '0) && (lo_c < size_c) && (lo_c <= hi_c);
  assign hi_clip   = (hi_c >= size_c) ? (size_c - CW'(1)) : hi_c;
  assign leaf_node = AW'(pos_c + ML_C);
  assign a_init    = PW'(lo_c + ML_C);
  assign b_init    = PW'(hi_clip + ML_C + CW'(1));
  assign b_dec     = b_r[0] ? (b_r - PW'(1)) : b_r;

  // Shared adder: node plus delta on the add walk, accumulator plus node on a query
  assign opb     = (state_r == S_AWR) ?
                   {{(SUM_W-DELTA_W){delta_r[DELTA_W-1]}}, delta_r} : acc_r;
  assign sum     = mem_rdata + opb;
  assign acc_upd = rd_pend_r ? sum : acc_r;

  assign in_stall = (state_r != S_IDLE);
  assign res_sum  = acc_upd;

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    clr_idx_nxt   = clr_idx_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    delta_nxt     = delta_r;
    rd_pend_nxt   = 1'b0;
    res_done      = 1'b0;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    mem_waddr     = node_r;
    mem_raddr     = node_r;
    mem_wdata     = sum;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_ADD: begin
              if (add_ok) begin
                node_nxt  = leaf_node;
                delta_nxt = in_delta;
                state_nxt = S_ARD;
              end
            end
            OP_QUERY: begin
              acc_nxt   = '0;
              a_nxt     = q_ok ? a_init : '0;
              b_nxt     = q_ok ? b_init : '0;
              state_nxt = S_QA;
            end
            OP_CLEAR: begin
              clr_idx_nxt = '0;
              state_nxt   = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = clr_idx_r;
        mem_wdata     = '0;
        if (clr_idx_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      S_ARD: begin
        mem_ctl.rd_en = 1'b1;
        state_nxt     = S_AWR;
      end
      S_AWR: begin
        // add the delta to this node, then climb to its parent
        mem_ctl.wr_en = 1'b1;
        node_nxt      = node_r >> 1;
        state_nxt     = (node_r == ROOT_NODE) ? S_IDLE : S_ARD;
      end
      S_QA: begin
        acc_nxt = acc_upd;
        if (a_r < b_r) begin
          if (a_r[0]) begin
            mem_ctl.rd_en = 1'b1;
            mem_raddr     = a_r[AW-1:0];
            rd_pend_nxt   = 1'b1;
            a_nxt         = a_r + PW'(1);
          end
          state_nxt = S_QB;
        end else if (!res_hold) begin
          res_done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_QB: begin
        acc_nxt = acc_upd;
        if (b_r[0]) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = b_dec[AW-1:0];
          rd_pend_nxt   = 1'b1;
        end
        a_nxt     = a_r >> 1;
        b_nxt     = b_dec >> 1;
        state_nxt = S_QA;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_idx_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    delta_r <= delta_nxt;
  end

  `ST_ASSERT_ALWAYS(a_reset_sweeps, !rst_n |=> (state_r == S_CLR && clr_idx_r == '0), "reset must start the clearing sweep")
  `ST_ASSERT(a_span_order, (state_r == S_QA || state_r == S_QB) |-> (a_r <= b_r), "query bounds crossed")
  `ST_ASSERT(a_add_pair, (state_r == S_ARD) |=> (state_r == S_AWR && $stable(node_r)), "add walk lost its node")
  `ST_ASSERT(a_pend_query, rd_pend_r |-> (state_r == S_QA || state_r == S_QB), "read pending outside a query")

endmodule

// ===== src/segment_tree_point_add_range_sum.sv =====
`timescale 1ns / 1ps
`include "segment_tree_point_add_range_sum_assert.svh"
// ----------------------------------------------------------------------------
// segment_tree_point_add_range_sum
// Point-add / range-sum tree over 2*MAX_LEAVES 64-bit node sums, walked by
// a small sequencer around one shared adder and a single node store.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Word
// -------   --------------------   -----------------------------------------
// in        in_valid / in_stall    op, position, delta, range_low, range_high
// out       out_valid / out_stall  range_sum (queries only)
// cfg       cfg_valid / cfg_ready  active_size
//
// Add: at each tree level a store read, then a write of node + delta,
//   from the leaf up to the root.
// Query: a bottom-up span walk, states QA then QB at each level, with at most
//   one store read in each; empty spans end in the first QA state, unread.
// Clear, and every reset: a sweep writing zero over all 2*MAX_LEAVES nodes,
//   one node per cycle; no word is taken meanwhile.
// A result waiting on out_stall holds the output register; a later query
//   finishing meanwhile waits for it, and no word is taken until then.
//
module segment_tree_point_add_range_sum #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [segtree_pkg::OP_W-1:0]           in_op,
  input  logic [segtree_pkg::POS_W-1:0]          in_position,
  input  logic signed [segtree_pkg::DELTA_W-1:0] in_delta,
  input  logic [segtree_pkg::POS_W-1:0]          in_range_low,
  input  logic [segtree_pkg::POS_W-1:0]          in_range_high,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [segtree_pkg::SUM_W-1:0]   out_range_sum,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [segtree_pkg::SIZE_W-1:0]         cfg_active_size
);
  import segtree_pkg::*;

  localparam int AW = $clog2(2 * MAX_LEAVES);

  logic [SIZE_W-1:0] active_size_r, active_size_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_sum_r, out_sum_nxt;

  logic              res_hold;
  logic              res_done;
  logic [SUM_W-1:0]  res_sum;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [SUM_W-1:0]  mem_wdata, mem_rdata;

  // Size register: always writable, the store is left as it is
  assign cfg_ready       = 1'b1;
  assign active_size_nxt = (cfg_valid && cfg_ready) ? cfg_active_size : active_size_r;

  // Output register: hold a word until taken, load on query completion
  assign res_hold      = out_valid_r && out_stall;
  assign out_valid_nxt = res_done ? 1'b1 : res_hold;
  assign out_sum_nxt   = res_done ? res_sum : out_sum_r;

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= SIZE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      active_size_r <= active_size_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
  end

  segtree_ctrl #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_delta      (in_delta),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .active_size   (active_size_r),
    .res_hold      (res_hold),
    .res_done      (res_done),
    .res_sum       (res_sum),
    .mem_ctl       (mem_ctl),
    .mem_waddr     (mem_waddr),
    .mem_raddr     (mem_raddr),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata)
  );

  segtree_mem #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (mem_waddr),
    .raddr   (mem_raddr),
    .wdata   (mem_wdata),
    .rdata   (mem_rdata)
  );

  `ST_ASSERT(a_no_overwrite, res_done |-> !(out_valid_r && out_stall), "result overwrote a held word")
  `ST_ASSERT(a_done_busy, res_done |-> in_stall, "result completed while idle")

endmodule
